@@ sv/assert_macros.svh @@
// assertion macros, included by accel_pitch_angle.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on the rising clock edge
`define APA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication, sampled on the rising clock edge
`define APA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define APA_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define APA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/apa_pkg.sv @@
// shared types, widths and constants for the pitch angle pipeline
`timescale 1ns / 1ps

package apa_pkg;

   // iteration count, capped at the arctangent table length
   localparam int CORDIC_STAGES   = 16;
   localparam int ANGLE_TABLE_LEN = 24;
   localparam int NUM_ITER = (CORDIC_STAGES > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN
                                                               : CORDIC_STAGES;

   // datapath widths
   localparam int SAMPLE_W      = 16;
   localparam int PITCH_W       = 16;
   localparam int PRESCALE_BITS = 24;
   localparam int VEC_W         = SAMPLE_W + 2 + PRESCALE_BITS;
   localparam int EXT_W         = VEC_W - (SAMPLE_W + 1) - PRESCALE_BITS;
   localparam int ACC_W         = 29;
   localparam int OUT_SHIFT     = 12;
   localparam int Q_W           = ACC_W - OUT_SHIFT;

   // angles: accumulator in 2^-19 degree, output in 1/128 degree
   localparam int HALF_TURN_UNITS  = 94371840;
   localparam int HALF_TURN_OUT    = 23040;
   localparam int QUARTER_TURN_OUT = 11520;
   localparam int ROUND_BIAS       = 2048;

   localparam logic signed [ACC_W-1:0]   ACC_HALF     = ACC_W'(HALF_TURN_UNITS);
   localparam logic signed [ACC_W-1:0]   ACC_BIAS     = ACC_W'(ROUND_BIAS);
   localparam logic signed [Q_W-1:0]     Q_HI         = Q_W'(HALF_TURN_OUT);
   localparam logic signed [Q_W-1:0]     Q_LO         = Q_W'(-HALF_TURN_OUT);
   localparam logic signed [PITCH_W-1:0] PITCH_HI     = PITCH_W'(HALF_TURN_OUT);
   localparam logic signed [PITCH_W-1:0] PITCH_LO     = PITCH_W'(-HALF_TURN_OUT);
   localparam logic signed [PITCH_W-1:0] PITCH_UP90   = PITCH_W'(QUARTER_TURN_OUT);
   localparam logic signed [PITCH_W-1:0] PITCH_DOWN90 = PITCH_W'(-QUARTER_TURN_OUT);
   localparam logic signed [PITCH_W-1:0] PITCH_ZERO   = '0;

   // atan(2^-i) in 2^-19 degree
   localparam logic signed [ACC_W-1:0] ANGLE_STEP [ANGLE_TABLE_LEN] = '{
      ACC_W'(23592960), ACC_W'(13927738), ACC_W'(7359034), ACC_W'(3735561),
      ACC_W'(1875029),  ACC_W'(938429),   ACC_W'(469329),  ACC_W'(234679),
      ACC_W'(117341),   ACC_W'(58671),    ACC_W'(29335),   ACC_W'(14668),
      ACC_W'(7334),     ACC_W'(3667),     ACC_W'(1833),    ACC_W'(917),
      ACC_W'(458),      ACC_W'(229),      ACC_W'(115),     ACC_W'(57),
      ACC_W'(29),       ACC_W'(14),       ACC_W'(7),       ACC_W'(4)
   };

   // one item in flight through the rotation stages
   typedef struct packed {
      logic                      special;
      logic signed [PITCH_W-1:0] spec_pitch;
      logic signed [VEC_W-1:0]   vx;
      logic signed [VEC_W-1:0]   vy;
      logic signed [ACC_W-1:0]   acc;
   } cordic_type;

endpackage

@@ sv/apa_if.sv @@
// sample and result channel interfaces
`timescale 1ns / 1ps

interface apa_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [apa_pkg::SAMPLE_W-1:0] x_sample;
   logic signed [apa_pkg::SAMPLE_W-1:0] z_sample;

   modport source (output valid, output x_sample, output z_sample, input ready);
   modport sink   (input valid, input x_sample, input z_sample, output ready);
endinterface

interface apa_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [apa_pkg::PITCH_W-1:0] pitch;

   modport source (output valid, output pitch, input ready);
   modport sink   (input valid, input pitch, output ready);
endinterface

@@ sv/accel_pitch_angle.sv @@
// Pitch angle from an X/Z accelerometer sample pair, atan2(-x, z) in degrees.
//
// req_ch carries one x_sample / z_sample pair per transfer (raw signed words).
// rsp_ch returns one pitch per request, signed, in 1/128 degree steps,
// from -180 to +180 degrees, in the order the samples came in.
// From request transfer to result valid, an item passes one input stage,
// one register per CORDIC micro-rotation (16 by default),
// and the rounding stage that drives rsp_ch.
// Throughput is one pair per clock while rsp_ch is ready; every stage holds
// its own valid bit. When the receiver stalls, items pile up stage by stage
// behind the result register, so empty stages still fill and req_ch.ready
// drops only once the whole pipeline is full. Nothing is dropped or repeated
// across a stall. Synchronous reset empties every stage; data is not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module accel_pitch_angle (
   input logic         clock,
   input logic         reset,
   apa_req_if.sink     req_ch,
   apa_rsp_if.source   rsp_ch
);

   logic                pre_valid;
   logic                pre_ready;
   apa_pkg::cordic_type pre_data;
   logic                rot_valid;
   logic                rot_ready;
   apa_pkg::cordic_type rot_data;

   // quadrant fix-up and special cases
   apa_prerot u_prerot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .x_sample  (req_ch.x_sample),
      .z_sample  (req_ch.z_sample),
      .out_valid (pre_valid),
      .out_ready (pre_ready),
      .out_data  (pre_data)
   );

   // micro-rotation stages
   apa_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pre_valid),
      .in_ready  (pre_ready),
      .in_data   (pre_data),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_data  (rot_data)
   );

   // rounding and result register
   apa_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_ready  (rot_ready),
      .in_data   (rot_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .pitch     (rsp_ch.pitch)
   );

   // result never leaves the half-turn range
   `APA_ASSERT_IMPLIES(a_pitch_range, clock, reset, rsp_ch.valid, ($signed(rsp_ch.pitch) <= apa_pkg::PITCH_HI) && ($signed(rsp_ch.pitch) >= apa_pkg::PITCH_LO))

   // after pre-rotation a general vector lies strictly in the right half plane
   `APA_ASSERT_IMPLIES(a_prerot_right_half, clock, reset, pre_valid && !pre_data.special, !pre_data.vx[apa_pkg::VEC_W-1] && (pre_data.vx != '0))

   // reset empties the input stage and the result register
   `APA_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_ch.valid && !pre_valid)

endmodule

@@ sv/apa_prerot.sv @@
// input stage: special cases, half-turn pre-rotation and prescale
`timescale 1ns / 1ps

module apa_prerot (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [apa_pkg::SAMPLE_W-1:0] x_sample,
   input  logic signed [apa_pkg::SAMPLE_W-1:0] z_sample,
   output logic                                out_valid,
   input  logic                                out_ready,
   output apa_pkg::cordic_type                 out_data
);

   logic                                 valid_ff;
   apa_pkg::cordic_type                  data_ff;
   apa_pkg::cordic_type                  data_in;
   logic signed [apa_pkg::SAMPLE_W:0]    xs;
   logic signed [apa_pkg::SAMPLE_W:0]    zs;
   logic signed [apa_pkg::SAMPLE_W:0]    vx_s;
   logic signed [apa_pkg::SAMPLE_W:0]    vy_s;

   // stage advances when empty or when the next stage takes its item
   assign in_ready = !valid_ff || out_ready;

   // start vector (z, -x), turned by a half turn when z is negative
   always_comb begin
      xs = {x_sample[apa_pkg::SAMPLE_W-1], x_sample};
      zs = {z_sample[apa_pkg::SAMPLE_W-1], z_sample};
      data_in = '0;
      if (z_sample[apa_pkg::SAMPLE_W-1]) begin
         vx_s = -zs;
         vy_s = xs;
         data_in.acc = x_sample[apa_pkg::SAMPLE_W-1] ? apa_pkg::ACC_HALF
                                                     : -apa_pkg::ACC_HALF;
      end else begin
         vx_s = zs;
         vy_s = -xs;
      end
      data_in.vx = {{apa_pkg::EXT_W{vx_s[apa_pkg::SAMPLE_W]}}, vx_s,
                    {apa_pkg::PRESCALE_BITS{1'b0}}};
      data_in.vy = {{apa_pkg::EXT_W{vy_s[apa_pkg::SAMPLE_W]}}, vy_s,
                    {apa_pkg::PRESCALE_BITS{1'b0}}};

      // axis cases bypass the rotation
      if (x_sample == '0) begin
         data_in.special    = 1'b1;
         data_in.spec_pitch = z_sample[apa_pkg::SAMPLE_W-1] ? apa_pkg::PITCH_LO
                                                            : apa_pkg::PITCH_ZERO;
      end else if (z_sample == '0) begin
         data_in.special    = 1'b1;
         data_in.spec_pitch = x_sample[apa_pkg::SAMPLE_W-1] ? apa_pkg::PITCH_UP90
                                                            : apa_pkg::PITCH_DOWN90;
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ sv/apa_cordic.sv @@
// vectoring rotation pipeline, one micro-rotation per register stage
`timescale 1ns / 1ps

module apa_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  apa_pkg::cordic_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output apa_pkg::cordic_type out_data
);

   localparam int N = apa_pkg::NUM_ITER;

   logic                valid_ff    [N];
   apa_pkg::cordic_type data_ff     [N];
   logic                stage_ready [N];

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_stage
         apa_pkg::cordic_type                up;
         apa_pkg::cordic_type                data_in;
         logic                               up_valid;
         logic                               down_ready;
         logic signed [apa_pkg::VEC_W-1:0]   dx;
         logic signed [apa_pkg::VEC_W-1:0]   dy;

         // neighbors in the chain
         if (i == 0) begin : g_first
            assign up       = in_data;
            assign up_valid = in_valid;
         end else begin : g_mid
            assign up       = data_ff[i-1];
            assign up_valid = valid_ff[i-1];
         end
         if (i == N - 1) begin : g_last
            assign down_ready = out_ready;
         end else begin : g_inner
            assign down_ready = stage_ready[i+1];
         end

         assign stage_ready[i] = !valid_ff[i] || down_ready;

         // turn toward the x axis, steering on the sign of y
         always_comb begin
            data_in = up;
            dx = $signed(up.vy) >>> i;
            dy = $signed(up.vx) >>> i;
            if (!up.vy[apa_pkg::VEC_W-1]) begin
               data_in.vx  = up.vx + dx;
               data_in.vy  = up.vy - dy;
               data_in.acc = up.acc + apa_pkg::ANGLE_STEP[i];
            end else begin
               data_in.vx  = up.vx - dx;
               data_in.vy  = up.vy + dy;
               data_in.acc = up.acc - apa_pkg::ANGLE_STEP[i];
            end
         end

         // stage register
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (stage_ready[i]) begin
               valid_ff[i] <= up_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (stage_ready[i] && up_valid) begin
               data_ff[i] <= data_in;
            end
         end
      end
   endgenerate

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[N-1];
   assign out_data  = data_ff[N-1];

endmodule

@@ sv/apa_round.sv @@
// output stage: round to 1/128 degree, saturate, result register
`timescale 1ns / 1ps

module apa_round (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  apa_pkg::cordic_type                in_data,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [apa_pkg::PITCH_W-1:0] pitch
);

   logic                               valid_ff;
   logic signed [apa_pkg::PITCH_W-1:0] pitch_ff;
   logic signed [apa_pkg::PITCH_W-1:0] pitch_in;
   logic signed [apa_pkg::ACC_W-1:0]   biased;
   logic signed [apa_pkg::Q_W-1:0]     q;

   assign in_ready = !valid_ff || out_ready;

   // round half up, then clamp to a half turn either way
   always_comb begin
      biased = in_data.acc + apa_pkg::ACC_BIAS;
      q      = biased[apa_pkg::ACC_W-1:apa_pkg::OUT_SHIFT];
      if (in_data.special) begin
         pitch_in = in_data.spec_pitch;
      end else if (q > apa_pkg::Q_HI) begin
         pitch_in = apa_pkg::PITCH_HI;
      end else if (q < apa_pkg::Q_LO) begin
         pitch_in = apa_pkg::PITCH_LO;
      end else begin
         pitch_in = q[apa_pkg::PITCH_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pitch_ff <= pitch_in;
      end
   end

   assign out_valid = valid_ff;
   assign pitch     = pitch_ff;

endmodule

@@ bench/apa_pitch_check.sv @@
// scoreboard for the pitch angle pipeline: predicts every pitch and compares in order
`timescale 1ns / 1ps

module apa_pitch_check (
   input  logic clock,
   input  logic reset,
   apa_req_if   req_ch,
   apa_rsp_if   rsp_ch,
   output int   mismatch_count,
   output int   pitch_pending,
   output int   pairs_seen,
   output int   pitch_checked
);

   localparam int     CORDIC_STAGES = apa_pkg::CORDIC_STAGES;
   localparam int     SAMPLE_W      = apa_pkg::SAMPLE_W;
   localparam int     PITCH_W       = apa_pkg::PITCH_W;

   // rotation count, capped at the arctangent table length
   localparam int     ROT_STAGES   = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
   localparam int     PRE_SHIFT    = 24;
   localparam longint HALF_UNITS   = 64'sd94371840;
   localparam longint OUT_HALF     = 64'sd23040;
   localparam longint OUT_QUARTER  = 64'sd11520;
   localparam longint ROUND_HALF   = 64'sd2048;
   localparam int     ROUND_SHIFT  = 12;
   localparam int     REPORT_LIMIT = 10;

   // atan(2^-i) in 2^-19 degree
   localparam longint ATAN_TABLE [24] = '{
      23592960, 13927738, 7359034, 3735561, 1875029, 938429, 469329, 234679,
      117341, 58671, 29335, 14668, 7334, 3667, 1833, 917,
      458, 229, 115, 57, 29, 14, 7, 4
   };

   typedef struct {
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] z;
      logic signed [PITCH_W-1:0]  pitch;
   } pitch_entry_type;

   pitch_entry_type expected_pitch_q[$];

   // atan2(-x, z) in 1/128 degree by vectoring rotations on wide integers
   function automatic logic signed [PITCH_W-1:0] pitch_from_samples(
      input logic signed [SAMPLE_W-1:0] x,
      input logic signed [SAMPLE_W-1:0] z
   );
      longint vx, vy, acc, dx, dy, q;
      if (x == 0) return (z < 0) ? PITCH_W'(-OUT_HALF) : '0;
      if (z == 0) return (x > 0) ? PITCH_W'(-OUT_QUARTER) : PITCH_W'(OUT_QUARTER);
      vy  = -longint'(x);
      vx  = longint'(z);
      acc = 0;
      // left half plane: turn by 180 degrees first
      if (z < 0) begin
         acc = (vy > 0) ? HALF_UNITS : -HALF_UNITS;
         vx  = -vx;
         vy  = -vy;
      end
      vx = vx * (64'sd1 << PRE_SHIFT);
      vy = vy * (64'sd1 << PRE_SHIFT);
      for (int i = 0; i < ROT_STAGES; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy >= 0) begin
            vx  = vx + dx;
            vy  = vy - dy;
            acc = acc + ATAN_TABLE[i];
         end else begin
            vx  = vx - dx;
            vy  = vy + dy;
            acc = acc - ATAN_TABLE[i];
         end
      end
      // round half up, then clamp to a half turn
      q = (acc + ROUND_HALF) >>> ROUND_SHIFT;
      if (q > OUT_HALF) q = OUT_HALF;
      if (q < -OUT_HALF) q = -OUT_HALF;
      return q[PITCH_W-1:0];
   endfunction

   // record each sample transfer, check each pitch transfer against the oldest prediction
   always @(posedge clock) begin : track
      pitch_entry_type e;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            e.x     = req_ch.x_sample;
            e.z     = req_ch.z_sample;
            e.pitch = pitch_from_samples(req_ch.x_sample, req_ch.z_sample);
            expected_pitch_q.push_back(e);
            pairs_seen <= pairs_seen + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pitch_q.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("%0t: pitch %0d arrived with no sample pair pending",
                           $realtime, rsp_ch.pitch);
               mismatch_count <= mismatch_count + 1;
            end else begin
               e = expected_pitch_q.pop_front();
               if (rsp_ch.pitch !== e.pitch) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display("%0t: x=%0d z=%0d pitch expected %0d actual %0d",
                              $realtime, e.x, e.z, e.pitch, rsp_ch.pitch);
                  mismatch_count <= mismatch_count + 1;
               end
               pitch_checked <= pitch_checked + 1;
            end
         end
         pitch_pending <= expected_pitch_q.size();
      end
   end

endmodule

@@ bench/accel_pitch_angle_tb.sv @@
// top of the pitch angle testbench: clock, reset, sample stimulus, result stalls, verdict
`timescale 1ns / 1ps

module accel_pitch_angle_tb;

   localparam int SAMPLE_W       = apa_pkg::SAMPLE_W;
   localparam int NUM_ITER       = apa_pkg::NUM_ITER;
   localparam int RESET_CYCLES   = 10;
   localparam int LONG_HOLD      = 80;
   localparam int PRESSURE_ITEMS = 70;
   localparam int RANDOM_ITEMS   = 500;
   localparam int TAIL_ITEMS     = 230;
   localparam int SETTLE_CYCLES  = NUM_ITER + 6;
   localparam int WATCHDOG_LIMIT = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int  mismatch_count;
   int  pitch_pending;
   int  pairs_seen;
   int  pitch_checked;
   int  idle_cycles = 0;
   int  holds_done  = 0;
   bit  hold_request = 1'b0;
   bit  quiet_tail   = 1'b0;
   bit  gap_mode     = 1'b0;

   apa_req_if req_ch ();
   apa_rsp_if rsp_ch ();

   accel_pitch_angle i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   apa_pitch_check i_pitch_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .pitch_pending  (pitch_pending),
      .pairs_seen     (pairs_seen),
      .pitch_checked  (pitch_checked)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // offer one sample pair and hold it until the transfer
   task automatic send_pair(input logic signed [SAMPLE_W-1:0] x,
                            input logic signed [SAMPLE_W-1:0] z);
      req_ch.valid    <= 1'b1;
      req_ch.x_sample <= x;
      req_ch.z_sample <= z;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // drop valid for the given gap with junk on the sample lines
   task automatic idle_gap(input int cycles);
      req_ch.valid    <= 1'b0;
      req_ch.x_sample <= SAMPLE_W'($urandom);
      req_ch.z_sample <= SAMPLE_W'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // stop offering until every predicted pitch has come back
   task automatic drain_pitch();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pitch_pending != 0) @(posedge clock);
   endtask

   // pick an edge value of the sample range
   function automatic logic signed [SAMPLE_W-1:0] edge_sample();
      case ($urandom_range(0, 5))
         0:       return 16'sh8000;
         1:       return 16'sh8001;
         2:       return -16'sd1;
         3:       return 16'sd0;
         4:       return 16'sd1;
         default: return 16'sh7fff;
      endcase
   endfunction

   // random pair, weighted toward axes, the 180 degree seam and tiny vectors
   task automatic send_random_pair();
      logic signed [SAMPLE_W-1:0] x, z;
      int pick;
      pick = $urandom_range(0, 15);
      x = SAMPLE_W'($urandom);
      z = SAMPLE_W'($urandom);
      case (pick)
         8, 9: begin
            x = SAMPLE_W'($urandom_range(0, 15)) - 16'sd8;
            z = SAMPLE_W'($urandom_range(0, 15)) - 16'sd8;
         end
         10: x = '0;
         11: z = '0;
         12: z = -SAMPLE_W'($urandom_range(1, 4));
         13: begin
            x = SAMPLE_W'($urandom_range(0, 3)) - 16'sd2;
            z = -SAMPLE_W'($urandom_range(1, 32768));
         end
         14: begin
            x = edge_sample();
            z = edge_sample();
         end
         default: ;
      endcase
      send_pair(x, z);
   endtask

   // random items with bursty gaps that switch on and off in stretches
   task automatic random_run(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) gap_mode = ($urandom_range(0, 2) != 0);
         if (gap_mode && !quiet_tail && $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 4));
         send_random_pair();
      end
   endtask

   // sample stimulus
   initial begin
      req_ch.valid    = 1'b0;
      req_ch.x_sample = '0;
      req_ch.z_sample = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // axes, corners and the 180 degree seam
      send_pair(16'sd0, 16'sd0);
      send_pair(16'sd0, 16'sd1);
      send_pair(16'sd0, -16'sd1);
      send_pair(16'sd0, 16'sh7fff);
      send_pair(16'sd0, 16'sh8000);
      send_pair(16'sd1, 16'sd0);
      send_pair(-16'sd1, 16'sd0);
      send_pair(16'sh7fff, 16'sd0);
      send_pair(16'sh8000, 16'sd0);
      send_pair(16'sh7fff, 16'sh7fff);
      send_pair(16'sh8000, 16'sh8000);
      send_pair(16'sh7fff, 16'sh8000);
      send_pair(16'sh8000, 16'sh7fff);
      send_pair(16'sd1, -16'sd1);
      send_pair(-16'sd1, -16'sd1);
      send_pair(16'sd1, 16'sd1);
      send_pair(-16'sd1, 16'sd1);
      send_pair(-16'sd1, 16'sh8000);
      send_pair(16'sd1, 16'sh8000);
      send_pair(16'sh8000, -16'sd1);
      send_pair(16'sh7fff, -16'sd1);
      send_pair(16'sh5555, 16'shaaaa);
      send_pair(16'shaaaa, 16'sh5555);
      send_pair(16'sh0001, 16'sh7fff);
      drain_pitch();

      random_run(RANDOM_ITEMS);

      // result side holds off while samples keep coming, so the pipeline fills up
      hold_request = 1'b1;
      for (int i = 0; i < PRESSURE_ITEMS; i++) send_random_pair();
      drain_pitch();

      random_run(RANDOM_ITEMS);
      drain_pitch();

      // last stretch without any idling on either side
      quiet_tail = 1'b1;
      random_run(TAIL_ITEMS);
      drain_pitch();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d sample pairs and %0d pitch results, with axis, seam and edge",
               pairs_seen, pitch_checked);
      $display("values, bursty stalls on both sides and %0d full-pipeline hold", holds_done);
      if (mismatch_count == 0 && pitch_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // result side ready: bursty stalls, plain stretches, and one long hold on request
   initial begin : rsp_ready_drive
      int  span_left;
      bit  stall_mode;
      span_left  = 0;
      stall_mode = 1'b0;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (span_left == 0) begin
            stall_mode = ($urandom_range(0, 3) != 0);
            span_left  = $urandom_range(20, 60);
         end
         span_left--;
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
            holds_done++;
         end else if (quiet_tail || !stall_mode) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
